/* hw/rtl/mpsm_pkg.sv */
// Shared constants, codes and types of the multi-pattern string matcher.
// No dependencies; the matcher and checker refer to it by scoped names, the testbench imports it.
package mpsm_pkg;

    localparam int MAX_NODES   = 4096;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int CNT_W       = NODE_W + 1;
    localparam int ALPHA       = 26;
    localparam int CH_W        = 5;
    localparam int CHILD_DEPTH = MAX_NODES * ALPHA;
    localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
    localparam int CNT16_W     = 16;
    localparam logic [CNT16_W-1:0] SAT_MAX = 16'hFFFF;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_PAT   = 2'd1,
        CMD_BUILD = 2'd2,
        CMD_TEXT  = 2'd3
    } t_cmd;

    typedef enum logic [22:0] {
        ST_INIT   = 23'h000001,
        ST_IDLE   = 23'h000002,
        ST_LK0    = 23'h000004,
        ST_LK1    = 23'h000008,
        ST_LK2    = 23'h000010,
        ST_PAT    = 23'h000020,
        ST_PINC   = 23'h000040,
        ST_FWAIT  = 23'h000080,
        ST_BPOP   = 23'h000100,
        ST_BNOW   = 23'h000200,
        ST_BNF    = 23'h000400,
        ST_BCH    = 23'h000800,
        ST_BFW    = 23'h001000,
        ST_BFR    = 23'h002000,
        ST_BNXT   = 23'h004000,
        ST_TCLR0  = 23'h008000,
        ST_TCLR1  = 23'h010000,
        ST_TSTART = 23'h020000,
        ST_TWALK  = 23'h040000,
        ST_TFR    = 23'h080000,
        ST_CH1    = 23'h100000,
        ST_TEND   = 23'h200000,
        ST_EMIT   = 23'h400000
    } t_state;

    // child slot address: node * ALPHA + letter
    function automatic logic [CHILD_AW-1:0] slot_addr(input logic [NODE_W-1:0] node,
                                                      input logic [CH_W-1:0] ch);
        slot_addr = CHILD_AW'(node) * CHILD_AW'(ALPHA) + CHILD_AW'(ch);
    endfunction

endpackage

/* hw/rtl/mpsm_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hw/rtl/multi_pattern_string_matcher.sv */
// Top level of the Aho-Corasick multi-pattern string matcher.
// Depends on mpsm_pkg and mpsm_ram.
//
//  channel   dir  handshake                 contents
//  s_axis    in   tvalid/tready/tlast/tuser  tuser=cmd, tdata=letter, tlast=last
//  m_axis    out  tvalid/tready              tdata=match_count, overflow
//
// Work per word: a clear or a dropped pattern letter is done in idle; a pattern letter
// runs a child lookup (states LK0, LK1, LK2 on the child and parent memories). A text
// letter runs a lookup per failure hop and visits each node of its output chain, after
// the seen marks are cleared at text start. Build looks up every child slot of each
// node, plus one lookup per failure hop.
// Reset: a clearing pass writes all 4096 seen marks, tready low.
// Stalls: the result sits in an output register; a new word is accepted meanwhile.
module multi_pattern_string_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [mpsm_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,   // [4:0] ch, [7:5] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] cmd
    input  logic        i_s_axis_tlast,   // last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [mpsm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
                                          // [15:0] match_count, [16] overflow, [23:17] zero
);
    localparam int NW = mpsm_pkg::NODE_W;
    localparam int CW = mpsm_pkg::CNT_W;
    localparam int HW = mpsm_pkg::CH_W;
    localparam int EW = mpsm_pkg::CNT16_W;

    mpsm_pkg::t_state r_state, r_ret, r_fret;
    logic [HW-1:0] r_ch, r_lk_ch, r_i;
    logic          r_last, r_ovf, r_tact, r_rng, r_lk_hit, r_ovalid;
    logic [CW-1:0] r_nodes, r_head, r_tail, r_mark_cnt;
    logic [NW-1:0] r_ins, r_tpos, r_lk_node, r_lk_id, r_fa, r_now, r_nowfail, r_c, r_init;
    logic [EW-1:0] r_total;
    logic [mpsm_pkg::OUT_TDATA_W-1:0] r_odata;

    logic                          child_we;
    logic [mpsm_pkg::CHILD_AW-1:0] child_addr;
    logic [NW-1:0]                 child_q;
    logic                          par_we;
    logic [NW+HW-1:0]              par_q;
    logic                          fail_we;
    logic [NW-1:0]                 fail_waddr, fail_wdata, fail_q;
    logic                          end_we;
    logic [NW-1:0]                 end_waddr;
    logic [EW-1:0]                 end_wdata, end_q;
    logic                          seen_we, seen_q;
    logic [NW-1:0]                 seen_waddr;
    logic                          q_we;
    logic [NW-1:0]                 q_waddr, q_wdata, q_q;
    logic                          mark_we;
    logic [NW-1:0]                 mark_raddr, mark_q;

    logic          acc, alloc, bwrite, push, hitmark;
    logic [NW-1:0] push_node;
    logic [EW:0]   sum;
    logic [EW-1:0] n_total;
    logic [CW-1:0] mark_dec;

    assign o_s_axis_tready = (r_state == mpsm_pkg::ST_IDLE);
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // node allocation on a missed pattern lookup with room left
    assign alloc = (r_state == mpsm_pkg::ST_PAT) && !r_lk_hit &&
                   (r_nodes < CW'(mpsm_pkg::MAX_NODES));
    // failure link write during build
    assign bwrite = ((r_state == mpsm_pkg::ST_BCH) && r_lk_hit && (r_now == '0)) ||
                    ((r_state == mpsm_pkg::ST_BFW) && (r_lk_hit || (r_lk_node == '0)));
    assign push_node = (r_state == mpsm_pkg::ST_BCH) ? r_lk_id : r_c;
    assign push      = bwrite && (r_tail < CW'(mpsm_pkg::MAX_NODES));
    assign hitmark   = (r_state == mpsm_pkg::ST_CH1) && (end_q != '0) && !seen_q;
    assign sum       = {1'b0, r_total} + {1'b0, end_q};
    assign n_total   = sum[EW] ? mpsm_pkg::SAT_MAX : sum[EW-1:0];
    assign mark_dec  = r_mark_cnt - CW'(1);

    always_comb begin
        child_addr = mpsm_pkg::slot_addr(r_lk_node, r_lk_ch);
        child_we   = alloc;
        par_we     = alloc;
        fail_we    = alloc || bwrite;
        fail_waddr = alloc ? r_nodes[NW-1:0] : push_node;
        fail_wdata = ((r_state == mpsm_pkg::ST_BFW) && r_lk_hit) ? r_lk_id : '0;
        end_we     = alloc || ((r_state == mpsm_pkg::ST_PINC) && (end_q != mpsm_pkg::SAT_MAX));
        end_waddr  = alloc ? r_nodes[NW-1:0] : r_fa;
        end_wdata  = alloc ? EW'(r_last) : end_q + EW'(1);
        seen_we    = (r_state == mpsm_pkg::ST_INIT) || (r_state == mpsm_pkg::ST_TCLR1) ||
                     hitmark;
        seen_waddr = (r_state == mpsm_pkg::ST_INIT)  ? r_init :
                     (r_state == mpsm_pkg::ST_TCLR1) ? mark_q : r_fa;
        q_we       = (acc && (i_s_axis_tuser == mpsm_pkg::CMD_BUILD)) || push;
        q_waddr    = (r_state == mpsm_pkg::ST_IDLE) ? '0 : r_tail[NW-1:0];
        q_wdata    = (r_state == mpsm_pkg::ST_IDLE) ? '0 : push_node;
        mark_we    = hitmark;
        mark_raddr = mark_dec[NW-1:0];
    end

    mpsm_ram #(.WIDTH(NW), .DEPTH(mpsm_pkg::CHILD_DEPTH)) u_child (
        .i_clk(i_clk), .i_we(child_we), .i_waddr(child_addr), .i_wdata(r_nodes[NW-1:0]),
        .i_raddr(child_addr), .o_rdata(child_q));
    // parent and letter of each node: validates stale child slots
    mpsm_ram #(.WIDTH(NW+HW), .DEPTH(mpsm_pkg::MAX_NODES)) u_par (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(r_nodes[NW-1:0]),
        .i_wdata({r_lk_node, r_lk_ch}), .i_raddr(child_q), .o_rdata(par_q));
    mpsm_ram #(.WIDTH(NW), .DEPTH(mpsm_pkg::MAX_NODES)) u_fail (
        .i_clk(i_clk), .i_we(fail_we), .i_waddr(fail_waddr), .i_wdata(fail_wdata),
        .i_raddr(r_fa), .o_rdata(fail_q));
    mpsm_ram #(.WIDTH(EW), .DEPTH(mpsm_pkg::MAX_NODES)) u_end (
        .i_clk(i_clk), .i_we(end_we), .i_waddr(end_waddr), .i_wdata(end_wdata),
        .i_raddr(r_fa), .o_rdata(end_q));
    mpsm_ram #(.WIDTH(1), .DEPTH(mpsm_pkg::MAX_NODES)) u_seen (
        .i_clk(i_clk), .i_we(seen_we), .i_waddr(seen_waddr),
        .i_wdata(r_state == mpsm_pkg::ST_CH1), .i_raddr(r_fa), .o_rdata(seen_q));
    mpsm_ram #(.WIDTH(NW), .DEPTH(mpsm_pkg::MAX_NODES)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(r_head[NW-1:0]), .o_rdata(q_q));
    // list of nodes marked seen in the current text, unwound at next text start
    mpsm_ram #(.WIDTH(NW), .DEPTH(mpsm_pkg::MAX_NODES)) u_mark (
        .i_clk(i_clk), .i_we(mark_we), .i_waddr(r_mark_cnt[NW-1:0]), .i_wdata(r_fa),
        .i_raddr(mark_raddr), .o_rdata(mark_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mpsm_pkg::ST_INIT;
            r_init     <= '0;
            r_nodes    <= CW'(1);
            r_ins      <= '0;
            r_tpos     <= '0;
            r_total    <= '0;
            r_ovf      <= 1'b0;
            r_tact     <= 1'b0;
            r_mark_cnt <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            // the emit state sets the output register itself
            if (r_ovalid && i_m_axis_tready && (r_state != mpsm_pkg::ST_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                mpsm_pkg::ST_INIT: begin
                    r_init <= r_init + NW'(1);
                    if (r_init == NW'(mpsm_pkg::MAX_NODES - 1)) begin
                        r_state <= mpsm_pkg::ST_IDLE;
                    end
                end
                mpsm_pkg::ST_IDLE: begin
                    if (acc) begin
                        r_ch   <= i_s_axis_tdata[HW-1:0];
                        r_last <= i_s_axis_tlast;
                        unique case (i_s_axis_tuser)
                            mpsm_pkg::CMD_CLEAR: begin
                                r_nodes <= CW'(1);
                                r_ins   <= '0;
                                r_tpos  <= '0;
                                r_total <= '0;
                                r_ovf   <= 1'b0;
                                r_tact  <= 1'b0;
                            end
                            mpsm_pkg::CMD_PAT: begin
                                if (i_s_axis_tdata[HW-1:0] < HW'(mpsm_pkg::ALPHA)) begin
                                    r_lk_node <= r_ins;
                                    r_lk_ch   <= i_s_axis_tdata[HW-1:0];
                                    r_ret     <= mpsm_pkg::ST_PAT;
                                    r_state   <= mpsm_pkg::ST_LK0;
                                end else if (i_s_axis_tlast) begin
                                    r_ins <= '0;
                                end
                            end
                            mpsm_pkg::CMD_BUILD: begin
                                r_head  <= '0;
                                r_tail  <= CW'(1);
                                r_state <= mpsm_pkg::ST_BPOP;
                            end
                            mpsm_pkg::CMD_TEXT: begin
                                if (!r_tact) begin
                                    r_total <= '0;
                                    r_tpos  <= '0;
                                    r_tact  <= 1'b1;
                                    r_state <= (r_mark_cnt != '0) ? mpsm_pkg::ST_TCLR0
                                                                  : mpsm_pkg::ST_TSTART;
                                end else begin
                                    r_state <= mpsm_pkg::ST_TSTART;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                // child lookup: slot read, range check, parent check
                mpsm_pkg::ST_LK0: r_state <= mpsm_pkg::ST_LK1;
                mpsm_pkg::ST_LK1: begin
                    r_lk_id <= child_q;
                    r_rng   <= (child_q != '0) && ({1'b0, child_q} < r_nodes);
                    r_state <= mpsm_pkg::ST_LK2;
                end
                mpsm_pkg::ST_LK2: begin
                    r_lk_hit <= r_rng && (par_q == {r_lk_node, r_lk_ch});
                    r_state  <= r_ret;
                end
                mpsm_pkg::ST_FWAIT: r_state <= r_fret;
                mpsm_pkg::ST_PAT: begin
                    if (r_lk_hit && r_last) begin
                        r_fa    <= r_lk_id;
                        r_fret  <= mpsm_pkg::ST_PINC;
                        r_state <= mpsm_pkg::ST_FWAIT;
                    end else begin
                        r_state <= mpsm_pkg::ST_IDLE;
                        if (r_lk_hit) begin
                            r_ins <= r_lk_id;
                        end else if (alloc) begin
                            r_nodes <= r_nodes + CW'(1);
                            r_ins   <= r_last ? '0 : r_nodes[NW-1:0];
                        end else begin
                            r_ovf <= 1'b1;
                            if (r_last) begin
                                r_ins <= '0;
                            end
                        end
                    end
                end
                mpsm_pkg::ST_PINC: begin
                    r_ins   <= '0;
                    r_state <= mpsm_pkg::ST_IDLE;
                end
                // breadth-first build of failure links
                mpsm_pkg::ST_BPOP: begin
                    if (r_head < r_tail) begin
                        r_head  <= r_head + CW'(1);
                        r_state <= mpsm_pkg::ST_BNOW;
                    end else begin
                        r_tpos  <= '0;
                        r_tact  <= 1'b0;
                        r_state <= mpsm_pkg::ST_IDLE;
                    end
                end
                mpsm_pkg::ST_BNOW: begin
                    r_now   <= q_q;
                    r_fa    <= q_q;
                    r_i     <= '0;
                    r_fret  <= mpsm_pkg::ST_BNF;
                    r_state <= mpsm_pkg::ST_FWAIT;
                end
                mpsm_pkg::ST_BNF: begin
                    r_nowfail <= fail_q;
                    r_lk_node <= r_now;
                    r_lk_ch   <= r_i;
                    r_ret     <= mpsm_pkg::ST_BCH;
                    r_state   <= mpsm_pkg::ST_LK0;
                end
                mpsm_pkg::ST_BCH: begin
                    if (r_lk_hit && (r_now != '0)) begin
                        r_c       <= r_lk_id;
                        r_lk_node <= r_nowfail;
                        r_ret     <= mpsm_pkg::ST_BFW;
                        r_state   <= mpsm_pkg::ST_LK0;
                    end else begin
                        if (push) begin
                            r_tail <= r_tail + CW'(1);
                        end
                        r_state <= mpsm_pkg::ST_BNXT;
                    end
                end
                mpsm_pkg::ST_BFW: begin
                    if (bwrite) begin
                        if (push) begin
                            r_tail <= r_tail + CW'(1);
                        end
                        r_state <= mpsm_pkg::ST_BNXT;
                    end else begin
                        r_fa    <= r_lk_node;
                        r_fret  <= mpsm_pkg::ST_BFR;
                        r_state <= mpsm_pkg::ST_FWAIT;
                    end
                end
                mpsm_pkg::ST_BFR: begin
                    r_lk_node <= fail_q;
                    r_ret     <= mpsm_pkg::ST_BFW;
                    r_state   <= mpsm_pkg::ST_LK0;
                end
                mpsm_pkg::ST_BNXT: begin
                    if (r_i == HW'(mpsm_pkg::ALPHA - 1)) begin
                        r_state <= mpsm_pkg::ST_BPOP;
                    end else begin
                        r_i       <= r_i + HW'(1);
                        r_lk_node <= r_now;
                        r_lk_ch   <= r_i + HW'(1);
                        r_ret     <= mpsm_pkg::ST_BCH;
                        r_state   <= mpsm_pkg::ST_LK0;
                    end
                end
                // text start: unwind seen marks of the previous text
                mpsm_pkg::ST_TCLR0: r_state <= mpsm_pkg::ST_TCLR1;
                mpsm_pkg::ST_TCLR1: begin
                    r_mark_cnt <= mark_dec;
                    r_state    <= (mark_dec == '0) ? mpsm_pkg::ST_TSTART : mpsm_pkg::ST_TCLR0;
                end
                mpsm_pkg::ST_TSTART: begin
                    if (r_ch < HW'(mpsm_pkg::ALPHA)) begin
                        r_lk_node <= r_tpos;
                        r_lk_ch   <= r_ch;
                        r_ret     <= mpsm_pkg::ST_TWALK;
                        r_state   <= mpsm_pkg::ST_LK0;
                    end else begin
                        r_tpos  <= '0;
                        r_state <= mpsm_pkg::ST_TEND;
                    end
                end
                mpsm_pkg::ST_TWALK: begin
                    if (r_lk_hit) begin
                        r_tpos  <= r_lk_id;
                        r_fa    <= r_lk_id;
                        r_fret  <= mpsm_pkg::ST_CH1;
                        r_state <= mpsm_pkg::ST_FWAIT;
                    end else if (r_lk_node != '0) begin
                        r_fa    <= r_lk_node;
                        r_fret  <= mpsm_pkg::ST_TFR;
                        r_state <= mpsm_pkg::ST_FWAIT;
                    end else begin
                        r_tpos  <= '0;
                        r_state <= mpsm_pkg::ST_TEND;
                    end
                end
                mpsm_pkg::ST_TFR: begin
                    r_lk_node <= fail_q;
                    r_ret     <= mpsm_pkg::ST_TWALK;
                    r_state   <= mpsm_pkg::ST_LK0;
                end
                // output chain: count each terminal node once per text
                mpsm_pkg::ST_CH1: begin
                    if (hitmark) begin
                        r_total    <= n_total;
                        r_mark_cnt <= r_mark_cnt + CW'(1);
                    end
                    if (fail_q != '0) begin
                        r_fa    <= fail_q;
                        r_state <= mpsm_pkg::ST_FWAIT;
                    end else begin
                        r_state <= mpsm_pkg::ST_TEND;
                    end
                end
                mpsm_pkg::ST_TEND: begin
                    r_state <= r_last ? mpsm_pkg::ST_EMIT : mpsm_pkg::ST_IDLE;
                end
                mpsm_pkg::ST_EMIT: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {7'b0, r_ovf, r_total};
                        r_tact   <= 1'b0;
                        r_tpos   <= '0;
                        r_state  <= mpsm_pkg::ST_IDLE;
                    end
                end
                default: r_state <= mpsm_pkg::ST_IDLE;
            endcase
        end
    end
endmodule

/* hw/rtl/mpsm_checker.sv */
// Port-level checks of the string matcher, bound to the top level.
// Depends on mpsm_pkg and multi_pattern_string_matcher.
module mpsm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [1:0]  i_s_axis_tuser,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata
);
    // clearing pass follows reset: no word taken right after
    a_init: assert property (@(posedge i_clk) !i_rst_n |=> !o_s_axis_tready)
        else $error("input ready right after reset");

    // a result only follows a last text letter
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready &&
         !((i_s_axis_tuser == mpsm_pkg::CMD_TEXT) && i_s_axis_tlast))
        |=> !$rose(o_m_axis_tvalid))
        else $error("result without a text end");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped under stall");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed under stall");
endmodule

bind multi_pattern_string_matcher mpsm_checker u_mpsm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready), .i_s_axis_tuser(i_s_axis_tuser),
    .i_s_axis_tlast(i_s_axis_tlast), .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready), .o_m_axis_tdata(o_m_axis_tdata));

/* tb/sv/tb_multi_pattern_string_matcher.sv */
// Self-checking testbench of the multi-pattern string matcher.
// Depends on mpsm_pkg and the matcher RTL; an Aho-Corasick predictor runs beside the block.
module tb_multi_pattern_string_matcher;
    import mpsm_pkg::*;

    localparam int HALF = 6;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;   // [4:0] ch, [7:5] zero
    logic [1:0]  i_s_axis_tuser = CMD_CLEAR;   // [1:0] cmd
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;        // [15:0] match_count, [16] overflow

    multi_pattern_string_matcher dut (.*);

    always #HALF i_clk = ~i_clk;

    typedef struct packed {
        logic [15:0] count;
        logic        ovf;
    } t_match;

    // predictor state
    logic [NODE_W-1:0] kid [0:CHILD_DEPTH-1];
    int          fail_of [MAX_NODES];
    logic [15:0] ends_at [MAX_NODES];
    bit          counted [MAX_NODES];
    int          bfs [MAX_NODES];
    int          n_used, ins_node, walk_node, tot;
    bit          tbl_full, in_text;

    t_match      pending_q[$];
    int          errors = 0;
    int          n_items = 0;
    bit          quiet = 1'b0;

    task automatic report(input string what);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    function automatic void fresh_node(input int n);
        for (int i = 0; i < ALPHA; i++) kid[n*ALPHA+i] = '0;
        fail_of[n] = 0;
        ends_at[n] = '0;
        counted[n] = 1'b0;
    endfunction

    function automatic void wipe_trie();
        fresh_node(0);
        n_used = 1; ins_node = 0; walk_node = 0; tot = 0;
        tbl_full = 1'b0; in_text = 1'b0;
    endfunction

    function automatic void insert_letter(input int ch, input bit last);
        bit drop;
        int slot;
        drop = 1'b0;
        if (ch >= ALPHA) begin
            drop = 1'b1;
        end else begin
            slot = ins_node*ALPHA + ch;
            if (kid[slot] == 0) begin
                if (n_used >= MAX_NODES) begin
                    tbl_full = 1'b1;
                    drop = 1'b1;
                end else begin
                    fresh_node(n_used);
                    kid[slot] = NODE_W'(n_used);
                    n_used++;
                end
            end
            if (!drop) ins_node = kid[slot];
        end
        if (last) begin
            if (!drop && ins_node != 0 && ends_at[ins_node] != 16'hFFFF)
                ends_at[ins_node]++;
            ins_node = 0;
        end
    endfunction

    function automatic void link_failures();
        int head, tail, cur, c, p, g;
        head = 0; tail = 0;
        bfs[tail++] = 0;
        while (head < tail) begin
            cur = bfs[head++];
            for (int i = 0; i < ALPHA; i++) begin
                c = kid[cur*ALPHA+i];
                if (c != 0) begin
                    p = 0;
                    if (cur != 0) begin
                        p = fail_of[cur]; g = 0;
                        while (kid[p*ALPHA+i] == 0 && p != 0 && g < MAX_NODES) begin
                            p = fail_of[p]; g++;
                        end
                        p = kid[p*ALPHA+i];
                    end
                    fail_of[c] = p;
                    if (tail < MAX_NODES) bfs[tail++] = c;
                end
            end
        end
        walk_node = 0;
        in_text = 1'b0;
    endfunction

    function automatic void walk_letter(input int ch);
        int p, g;
        if (ch >= ALPHA) begin
            walk_node = 0;
            return;
        end
        p = walk_node; g = 0;
        while (kid[p*ALPHA+ch] == 0 && p != 0 && g < MAX_NODES) begin
            p = fail_of[p]; g++;
        end
        p = kid[p*ALPHA+ch];
        walk_node = p;
        g = 0;
        // scan the output chain; each terminal counts once per text
        while (p != 0 && g < MAX_NODES) begin
            if (ends_at[p] != 0 && !counted[p]) begin
                counted[p] = 1'b1;
                tot += ends_at[p];
                if (tot > 65535) tot = 65535;
            end
            p = fail_of[p]; g++;
        end
    endfunction

    // advance predictor by one accepted word; returns 1 when a result is due
    function automatic bit match_step(input t_cmd cmd, input int ch, input bit last,
                                      output t_match res);
        res = '0;
        case (cmd)
            CMD_CLEAR: wipe_trie();
            CMD_PAT:   insert_letter(ch, last);
            CMD_BUILD: link_failures();
            default: begin
                if (!in_text) begin
                    for (int i = 0; i < MAX_NODES; i++) counted[i] = 1'b0;
                    tot = 0; walk_node = 0; in_text = 1'b1;
                end
                walk_letter(ch);
                if (last) begin
                    res.count = 16'(tot);
                    res.ovf   = tbl_full;
                    in_text = 1'b0; walk_node = 0;
                    return 1'b1;
                end
            end
        endcase
        return 1'b0;
    endfunction

    // drive one word at the falling edge, hold until accepted
    task automatic put_word(input t_cmd cmd, input int ch, input bit last,
                            input bit typed = 1'b0, input t_match want = '0);
        t_match got;
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 12) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = cmd;
        i_s_axis_tdata  = {3'b000, 5'(ch)};
        i_s_axis_tlast  = last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_items++;
        if (match_step(cmd, ch, last, got))
            pending_q.push_back(typed ? want : got);
    endtask

    // result side: random stalls, compare at the rising edge
    always @(negedge i_clk)
        i_m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 12);

    always @(posedge i_clk) begin
        t_match want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result word %h", o_m_axis_tdata));
            end else begin
                want = pending_q.pop_front();
                if (o_m_axis_tdata[15:0] !== want.count)
                    report($sformatf("match_count %0d, want %0d",
                                     o_m_axis_tdata[15:0], want.count));
                if (o_m_axis_tdata[16] !== want.ovf)
                    report($sformatf("overflow %b, want %b", o_m_axis_tdata[16], want.ovf));
            end
        end
    end

    typedef struct {
        t_cmd   cmd;
        int     ch;
        bit     last;
        bit     typed;
        t_match want;
    } t_row;

    // directed part: h=7 e=4 s=18 i=8 r=17 u=20
    t_row directed [] = '{
        '{CMD_TEXT,  0,  1, 1, '{16'd0, 1'b0}},   // text on an empty trie
        '{CMD_PAT,   7,  0, 0, '0}, '{CMD_PAT, 4, 1, 0, '0},              // he
        '{CMD_PAT,  18,  0, 0, '0}, '{CMD_PAT, 7, 0, 0, '0},
        '{CMD_PAT,   4,  1, 0, '0},                                       // she
        '{CMD_PAT,   7,  0, 0, '0}, '{CMD_PAT, 8, 0, 0, '0},
        '{CMD_PAT,  18,  1, 0, '0},                                       // his
        '{CMD_PAT,   7,  0, 0, '0}, '{CMD_PAT, 4, 1, 0, '0},              // he again
        '{CMD_PAT,  31,  1, 0, '0},                                       // empty, bad letter
        '{CMD_PAT,  25,  0, 0, '0}, '{CMD_PAT, 26, 1, 0, '0},             // z then bad end
        '{CMD_BUILD, 0,  0, 0, '0},
        '{CMD_TEXT, 20,  0, 0, '0}, '{CMD_TEXT, 18, 0, 0, '0},
        '{CMD_TEXT,  7,  0, 0, '0}, '{CMD_TEXT, 4, 0, 0, '0},
        '{CMD_TEXT, 31,  0, 0, '0}, '{CMD_TEXT, 7, 0, 0, '0},
        '{CMD_TEXT,  4,  1, 0, '0},                                       // ushe?he
        '{CMD_CLEAR, 0,  0, 0, '0},
        '{CMD_TEXT,  4,  1, 1, '{16'd0, 1'b0}}    // cleared trie
    };

    task automatic random_letter_text(input int len, input int span);
        for (int k = 0; k < len; k++)
            put_word(CMD_TEXT, ($urandom_range(9) == 0) ? $urandom_range(31)
                                                         : $urandom_range(span),
                     k == len-1);
    endtask

    initial begin
        int span, npat, len;
        wipe_trie();
        for (int i = 0; i < MAX_NODES; i++) counted[i] = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[r])
            put_word(directed[r].cmd, directed[r].ch, directed[r].last,
                     directed[r].typed, directed[r].want);

        // random sessions: small tries, mostly over a narrow alphabet so texts hit often
        while (n_items < 750) begin
            quiet = (n_items > 300 && n_items < 450);
            if ($urandom_range(3) != 0) put_word(CMD_CLEAR, $urandom_range(31), $urandom_range(1));
            span = $urandom_range(1, 4) == 4 ? 25 : $urandom_range(1, 3);
            npat = $urandom_range(1, 6);
            for (int p = 0; p < npat; p++) begin
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++)
                    put_word(CMD_PAT, ($urandom_range(14) == 0) ? $urandom_range(31)
                                                                 : $urandom_range(span),
                             k == len-1);
            end
            if ($urandom_range(4) != 0) put_word(CMD_BUILD, $urandom_range(31), $urandom_range(1));
            if ($urandom_range(5) == 0) put_word(CMD_PAT, $urandom_range(span), 1'b1);
            repeat ($urandom_range(1, 4))
                random_letter_text($urandom_range(1, 10), span);
        end
        quiet = 1'b0;

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        for (int w = 0; w < 200000 && pending_q.size() != 0; w++) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(2 * HALF * 20_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
